// File: rtl/core/hlpc_pkg.sv
// Shared constants and types for the hypersphere lattice point counter.
// Used by hlpc_odometer and the top level; depends on nothing.
package hlpc_pkg;

	localparam int DIMS_W               = 4;
	localparam int RADIUS_W             = 12;
	localparam int COUNT_W              = 51;
	localparam int MAX_DIM_DEF          = 10;
	localparam int RADIUS_FRAC_BITS_DEF = 8;

	typedef struct packed {
		logic load;
		logic step;
	} odo_ctl_t;

endpackage

// File: rtl/core/hlpc_odometer.sv
// Radix-(2h+1) lattice odometer with a shared squared-distance update unit.
// Depends on hlpc_pkg for the control struct.
module hlpc_odometer #(
	parameter int MAX_DIM = hlpc_pkg::MAX_DIM_DEF,
	parameter int H_W     = 4,
	parameter int SW      = 12,
	parameter int DIM_W   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hlpc_pkg::odo_ctl_t  ctl,
	input  logic [H_W-1:0]      h,
	input  logic [DIM_W-1:0]    dims,
	input  logic [SW-1:0]       dist_init,
	output logic [SW-1:0]       sq_dist,
	output logic                last
);

	localparam int DW = H_W + 1;

	logic signed [DW-1:0] digit_q [MAX_DIM];
	logic [SW-1:0]        dist_q;
	logic signed [DW-1:0] pos_h;
	logic signed [DW-1:0] neg_h;
	logic [MAX_DIM-1:0]   inc_oh;
	logic [MAX_DIM-1:0]   wrap;
	logic                 found;
	logic [DW-1:0]        sel_digit;
	logic signed [DW:0]   delta;
	logic signed [SW:0]   delta_ext;
	logic signed [SW:0]   dist_sum;

	assign pos_h = $signed({1'b0, h});
	assign neg_h = -pos_h;

	always_comb begin
		found     = 1'b0;
		inc_oh    = '0;
		wrap      = '0;
		sel_digit = '0;
		for (int i = 0; i < MAX_DIM; i++) begin
			wrap[i] = !found;
			if (!found && (i < int'(dims)) && (digit_q[i] != pos_h)) begin
				found     = 1'b1;
				inc_oh[i] = 1'b1;
			end
			if (inc_oh[i]) begin
				sel_digit = sel_digit | digit_q[i];
			end
		end
	end

	assign delta     = {sel_digit, 1'b1};
	assign delta_ext = (SW + 1)'(delta);
	assign dist_sum  = $signed({1'b0, dist_q}) + delta_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			for (int i = 0; i < MAX_DIM; i++) begin
				digit_q[i] <= '0;
			end
		end else if (ctl.load) begin
			dist_q <= dist_init;
			for (int i = 0; i < MAX_DIM; i++) begin
				digit_q[i] <= neg_h;
			end
		end else if (ctl.step && found) begin
			dist_q <= dist_sum[SW-1:0];
			for (int i = 0; i < MAX_DIM; i++) begin
				if (inc_oh[i]) begin
					digit_q[i] <= digit_q[i] + DW'(1);
				end else if (wrap[i]) begin
					digit_q[i] <= neg_h;
				end
			end
		end
	end

	assign sq_dist = dist_q;
	assign last    = !found;

endmodule

// File: rtl/core/hypersphere_lattice_point_counter_core.sv
// Top level of the hypersphere lattice point counter: handshake, sequencer, count.
// Depends on hlpc_pkg and hlpc_odometer.
//
// One item walks every integer point of the cube [-h, h]^d, h = floor(radius), one point
// per clock, and counts those whose squared distance times 2^(2*RADIUS_FRAC_BITS) is
// below radius_fixed squared. The single odometer adder updates the squared distance once
// per point. Dimensions above MAX_DIM saturate to MAX_DIM, zero dimensions test one point
// at distance zero. in_ready is high only while no item is in work; a finished count waits
// in the output register, so a new item may be taken before it is read.
module hypersphere_lattice_point_counter_core #(
	parameter int MAX_DIM          = hlpc_pkg::MAX_DIM_DEF,
	parameter int RADIUS_FRAC_BITS = hlpc_pkg::RADIUS_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hlpc_pkg::DIMS_W-1:0]   dimensions,
	input  logic [hlpc_pkg::RADIUS_W-1:0] radius_fixed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hlpc_pkg::COUNT_W-1:0]  point_count
);

	localparam int RW     = hlpc_pkg::RADIUS_W;
	localparam int CNT_W  = hlpc_pkg::COUNT_W;
	localparam int F2     = 2 * RADIUS_FRAC_BITS;
	localparam int H_W    = (RW > RADIUS_FRAC_BITS) ? RW - RADIUS_FRAC_BITS : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int SW     = 2 * H_W + DIM_W;
	localparam int SQ_W   = 2 * RW;
	localparam int EXT_W  = SQ_W + F2 + 1;
	localparam int LIM_W  = (SQ_W > F2) ? SQ_W - F2 + 1 : 1;
	localparam int CMP_W  = (SW > LIM_W) ? SW : LIM_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_INIT  = 5'b00100,
		ST_RUN   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t               state_q;
	logic [DIM_W-1:0]     dims_q;
	logic [RW-1:0]        radius_q;
	logic [H_W-1:0]       h_q;
	logic [SQ_W-1:0]      sq_q;
	logic [2*H_W-1:0]     hsq_q;
	logic [LIM_W-1:0]     limit_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [CNT_W-1:0]     point_count_q;

	logic                 in_xfer;
	logic                 out_free;
	logic [DIM_W-1:0]     dims_sat;
	logic [H_W-1:0]       h_in;
	logic [EXT_W-1:0]     round_up;
	logic [EXT_W-1:0]     lim_sum;
	logic [SW-1:0]        dist_init;
	logic [SW-1:0]        odo_dist;
	logic                 odo_last;
	logic                 point_in;
	hlpc_pkg::odo_ctl_t   odo_ctl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign dims_sat  = (32'(dimensions) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(dimensions);
	assign h_in      = H_W'(radius_q >> RADIUS_FRAC_BITS);
	assign round_up  = (EXT_W'(1) << F2) - EXT_W'(1);
	assign lim_sum   = EXT_W'(sq_q) + round_up;
	assign dist_init = SW'(dims_q) * SW'(hsq_q);
	assign point_in  = CMP_W'(odo_dist) < CMP_W'(limit_q);

	assign odo_ctl.load = (state_q == ST_INIT);
	assign odo_ctl.step = (state_q == ST_RUN);

	hlpc_odometer #(
		.MAX_DIM (MAX_DIM),
		.H_W     (H_W),
		.SW      (SW),
		.DIM_W   (DIM_W)
	) u_odometer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (odo_ctl),
		.h         (h_q),
		.dims      (dims_q),
		.dist_init (dist_init),
		.sq_dist   (odo_dist),
		.last      (odo_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					count_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (point_in && (count_q != {CNT_W{1'b1}})) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (odo_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dims_q   <= dims_sat;
			radius_q <= radius_fixed;
		end
		if (state_q == ST_SETUP) begin
			h_q   <= h_in;
			sq_q  <= SQ_W'(radius_q) * SQ_W'(radius_q);
			hsq_q <= (2 * H_W)'(h_in) * (2 * H_W)'(h_in);
		end
		if (state_q == ST_INIT) begin
			limit_q <= LIM_W'(lim_sum >> F2);
		end
		if ((state_q == ST_FIN) && out_free) begin
			point_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_count = point_count_q;

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && odo_last) |=> (state_q == ST_FIN))
		else $error("walk did not end after the last lattice point");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");

	a_setup_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |-> $past(in_valid && in_ready))
		else $error("setup entered without an input transfer");

endmodule

// File: verif/hypersphere_lattice_point_counter_core_tb.sv
// Self-checking testbench for hypersphere_lattice_point_counter_core.
// Drives dimension/radius jobs through valid/ready, predicts each point count by
// squared-distance tallies, and checks results in order. Depends on hlpc_pkg.
`timescale 1ns / 100ps

module hypersphere_lattice_point_counter_core_tb;

	localparam int DIMS_W      = hlpc_pkg::DIMS_W;
	localparam int RADIUS_W    = hlpc_pkg::RADIUS_W;
	localparam int COUNT_W     = hlpc_pkg::COUNT_W;
	localparam int MAX_DIM     = hlpc_pkg::MAX_DIM_DEF;
	localparam int FRAC_BITS   = hlpc_pkg::RADIUS_FRAC_BITS_DEF;
	localparam int FLOOR_MAX   = ((1 << RADIUS_W) - 1) >> FRAC_BITS;
	localparam int DIST_SLOTS  = (FLOOR_MAX + 1) * (FLOOR_MAX + 1);
	localparam int VOLUME_CAP  = 2000;
	localparam int RANDOM_JOBS = 76;
	localparam int DRAIN_AT    = 60;
	localparam int HOLD_AT     = 30;
	localparam int HOLD_CYCLES = 3000;
	localparam int IDLE_LIMIT  = 250000;
	localparam int TAIL_CYCLES = 20;
	localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_W) - 64'd1;

	typedef struct {
		logic [DIMS_W-1:0]   dims;
		logic [RADIUS_W-1:0] radius;
		bit                  drain_first;
	} lattice_job_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [DIMS_W-1:0]   dimensions   = '0;
	logic [RADIUS_W-1:0] radius_fixed = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [COUNT_W-1:0]  point_count;

	lattice_job_t       job_queue[$];
	logic [COUNT_W-1:0] awaited_counts[$];
	int                 error_count = 0;
	int                 idle_cycles = 0;

	hypersphere_lattice_point_counter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.dimensions   (dimensions),
		.radius_fixed (radius_fixed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_count  (point_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned sat_sum(input longint unsigned a,
			input longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > COUNT_SAT || s < a) ? COUNT_SAT : s;
	endfunction

	function automatic logic [COUNT_W-1:0] count_inside_points(input logic [DIMS_W-1:0] dims_in,
			input logic [RADIUS_W-1:0] rad);
		longint unsigned tally[DIST_SLOTS];
		longint unsigned next_tally[DIST_SLOTS];
		longint unsigned rsq;
		longint unsigned bound;
		longint unsigned acc;
		longint unsigned total;
		int              dim_eff;
		rsq     = longint'(rad) * longint'(rad);
		bound   = (rsq + (64'd1 << (2 * FRAC_BITS)) - 64'd1) >> (2 * FRAC_BITS);
		dim_eff = (dims_in > MAX_DIM) ? MAX_DIM : int'(dims_in);
		total   = 0;
		if (bound > DIST_SLOTS)
			bound = DIST_SLOTS;
		if (bound == 0)
			return '0;
		foreach (tally[s])
			tally[s] = 0;
		tally[0] = 1;
		for (int d = 0; d < dim_eff; d++) begin
			foreach (next_tally[s])
				next_tally[s] = 0;
			for (int s = 0; s < bound; s++) begin
				acc = tally[s];
				for (int x = 1; x * x <= s; x++) begin
					acc = sat_sum(acc, tally[s - x * x]);
					acc = sat_sum(acc, tally[s - x * x]);
				end
				next_tally[s] = acc;
			end
			tally = next_tally;
		end
		for (int s = 0; s < bound; s++)
			total = sat_sum(total, tally[s]);
		return total[COUNT_W-1:0];
	endfunction

	task automatic add_job(input int d, input int r, input bit drain);
		lattice_job_t job;
		job.dims        = d[DIMS_W-1:0];
		job.radius      = r[RADIUS_W-1:0];
		job.drain_first = drain;
		job_queue.push_back(job);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lattice_job_t next_job;
		int           gap_left;
		int           burst_left;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			dimensions   <= '0;
			radius_fixed <= '0;
			gap_left   = 0;
			burst_left = 1;
		end else begin
			if (in_valid && in_ready)
				awaited_counts.push_back(count_inside_points(dimensions, radius_fixed));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (job_queue.size() == 0
						|| (job_queue[0].drain_first && awaited_counts.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					next_job = job_queue.pop_front();
					in_valid     <= 1'b1;
					dimensions   <= next_job.dims;
					radius_fixed <= next_job.radius;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 3) == 0) begin
							gap_left   = 0;
							burst_left = $urandom_range(15, 30);
						end else begin
							gap_left   = $urandom_range(1, 10);
							burst_left = $urandom_range(1, 6);
						end
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int rx_cycle;
		int hold_left;
		int counts_received;
		bit hold_done;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle        = 0;
			hold_left       = 0;
			counts_received = 0;
			hold_done       = 1'b0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				counts_received++;
				if (awaited_counts.size() == 0) begin
					$error("point_count: unexpected transfer, actual %0d", point_count);
					error_count++;
				end else if (point_count !== awaited_counts[0]) begin
					$error("point_count mismatch: expected %0d, actual %0d",
						awaited_counts[0], point_count);
					error_count++;
					void'(awaited_counts.pop_front());
				end else begin
					void'(awaited_counts.pop_front());
				end
			end
			if (counts_received == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cycle >> 6) & 3)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= rx_cycle[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("hypersphere_lattice_point_counter_core verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int radius;
		int base;
		int volume;
		int dim_max;
		int dims;

		add_job(0, 0, 1'b0);
		add_job(0, 1, 1'b0);
		add_job(0, 4095, 1'b0);
		add_job(1, 0, 1'b0);
		add_job(1, 256, 1'b0);
		add_job(1, 257, 1'b0);
		add_job(1, 3840, 1'b0);
		add_job(2, 1, 1'b0);
		add_job(2, 4095, 1'b0);
		add_job(3, 4095, 1'b0);
		add_job(4, 512, 1'b0);
		add_job(5, 768, 1'b0);
		add_job(6, 300, 1'b0);
		add_job(7, 255, 1'b0);
		add_job(8, 128, 1'b0);
		add_job(9, 511, 1'b0);
		add_job(10, 0, 1'b0);
		add_job(10, 300, 1'b0);
		add_job(11, 300, 1'b0);
		add_job(12, 255, 1'b0);
		add_job(13, 1, 1'b0);
		add_job(14, 200, 1'b0);
		add_job(15, 255, 1'b0);
		add_job(15, 0, 1'b0);

		for (int i = 0; i < RANDOM_JOBS; i++) begin
			radius  = $urandom_range(0, 1) ? $urandom_range(0, 767) : $urandom_range(0, 4095);
			base    = 2 * (radius >> FRAC_BITS) + 1;
			volume  = 1;
			dim_max = 0;
			while (dim_max < MAX_DIM && volume * base <= VOLUME_CAP) begin
				volume *= base;
				dim_max++;
			end
			dims = $urandom_range(0, dim_max);
			if (base == 1 && $urandom_range(0, 3) == 0)
				dims = $urandom_range(MAX_DIM + 1, (1 << DIMS_W) - 1);
			add_job(dims, radius, i == DRAIN_AT);
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (job_queue.size() != 0 || in_valid || awaited_counts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && awaited_counts.size() == 0)
			$display("hypersphere_lattice_point_counter_core verification clean");
		else
			$display("hypersphere_lattice_point_counter_core verification failed");
		$finish;
	end

endmodule
